// ===== rtl/core/esd_pkg.sv =====
// Shared types and character constants for the escape sequence decoder.
`timescale 1ns / 1ps

package esd_pkg;

  // Decoder mode codes.
  localparam logic [2:0] MODE_TEXT = 3'd0;
  localparam logic [2:0] MODE_ESC  = 3'd1;
  localparam logic [2:0] MODE_HEX0 = 3'd2;
  localparam logic [2:0] MODE_HEX1 = 3'd3;
  localparam logic [2:0] MODE_HEX2 = 3'd4;
  localparam logic [2:0] MODE_HEX3 = 3'd5;

  // Characters with a meaning in the escape syntax.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  // Control bytes produced by the short escapes.
  localparam logic [7:0] CTL_BS   = 8'h08;
  localparam logic [7:0] CTL_FF   = 8'h0C;
  localparam logic [7:0] CTL_LF   = 8'h0A;
  localparam logic [7:0] CTL_CR   = 8'h0D;
  localparam logic [7:0] CTL_TAB  = 8'h09;

  // Persistent decoder state.
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] acc;
    logic        skip;
  } dec_state_t;

  // Result group produced by one input byte (up to three bytes).
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] b;
    logic            end_mark;
    logic            bad;
  } dec_grp_t;

endpackage

// ===== rtl/core/esd_decode.sv =====
// Combinational decode of one input byte against the decoder state.
`timescale 1ns / 1ps

module esd_decode (
  input  logic [7:0]         char_i,
  input  esd_pkg::dec_state_t st_i,
  output esd_pkg::dec_state_t st_nxt,
  output esd_pkg::dec_grp_t   grp_o
);
  import esd_pkg::*;

  // Hex digit value; bit 4 flags a byte that is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
        t = c - CH_0;
        hex_val = {1'b0, t[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        t = c - CH_UA + 8'd10;
        hex_val = {1'b0, t[3:0]};
      end else if (c >= CH_LA && c <= CH_LF) begin
        t = c - CH_LA + 8'd10;
        hex_val = {1'b0, t[3:0]};
      end else begin
        hex_val = 5'h10;
      end
    end
  endfunction

  logic [4:0]  hv;
  logic [15:0] cp;
  logic        in_hex;

  assign hv     = hex_val(char_i);
  assign cp     = {st_i.acc[11:0], hv[3:0]};
  assign in_hex = (st_i.mode >= MODE_HEX0) && (st_i.mode <= MODE_HEX3);

  // Next state and result group, following the escape grammar.
  always_comb begin
    st_nxt         = st_i;
    grp_o.cnt      = 2'd0;
    grp_o.b        = '0;
    grp_o.end_mark = 1'b0;
    grp_o.bad      = 1'b0;
    if (st_i.skip) begin
      // After a bad digit, everything is dropped up to and including the terminator.
      if (char_i == CH_NUL) begin
        st_nxt.skip = 1'b0;
        st_nxt.mode = MODE_TEXT;
        st_nxt.acc  = 16'd0;
      end
    end else if (char_i == CH_NUL) begin
      st_nxt.mode    = MODE_TEXT;
      st_nxt.acc     = 16'd0;
      grp_o.cnt      = 2'd1;
      grp_o.end_mark = 1'b1;
      grp_o.bad      = in_hex;
    end else if (st_i.mode == MODE_ESC) begin
      st_nxt.mode = MODE_TEXT;
      grp_o.cnt   = 2'd1;
      case (char_i)
        CH_B:    grp_o.b[0] = CTL_BS;
        CH_F:    grp_o.b[0] = CTL_FF;
        CH_N:    grp_o.b[0] = CTL_LF;
        CH_R:    grp_o.b[0] = CTL_CR;
        CH_T:    grp_o.b[0] = CTL_TAB;
        CH_U: begin
          st_nxt.mode = MODE_HEX0;
          st_nxt.acc  = 16'd0;
          grp_o.cnt   = 2'd0;
        end
        default: grp_o.b[0] = char_i;
      endcase
    end else if (in_hex) begin
      if (hv[4]) begin
        st_nxt.mode    = MODE_TEXT;
        st_nxt.acc     = 16'd0;
        st_nxt.skip    = 1'b1;
        grp_o.cnt      = 2'd1;
        grp_o.end_mark = 1'b1;
        grp_o.bad      = 1'b1;
      end else if (st_i.mode != MODE_HEX3) begin
        st_nxt.acc  = cp;
        st_nxt.mode = st_i.mode + 3'd1;
      end else begin
        // Fourth digit: emit the code point as UTF-8.
        st_nxt.mode = MODE_TEXT;
        st_nxt.acc  = 16'd0;
        if (cp < 16'h0080) begin
          grp_o.cnt  = 2'd1;
          grp_o.b[0] = cp[7:0];
        end else if (cp < 16'h0800) begin
          grp_o.cnt  = 2'd2;
          grp_o.b[0] = {3'b110, cp[10:6]};
          grp_o.b[1] = {2'b10, cp[5:0]};
        end else begin
          grp_o.cnt  = 2'd3;
          grp_o.b[0] = {4'b1110, cp[15:12]};
          grp_o.b[1] = {2'b10, cp[11:6]};
          grp_o.b[2] = {2'b10, cp[5:0]};
        end
      end
    end else begin
      // Normal text, including the unused mode codes.
      st_nxt.mode = MODE_TEXT;
      if (char_i == CH_BSL) begin
        st_nxt.mode = MODE_ESC;
      end else begin
        grp_o.cnt  = 2'd1;
        grp_o.b[0] = char_i;
      end
    end
  end

endmodule

// ===== rtl/core/esd_out.sv =====
// Result register that holds one result group and hands it out byte by byte.
`timescale 1ns / 1ps

module esd_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  esd_pkg::dec_grp_t grp_i,
  output logic              free_o,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte_out,
  output logic              out_end_mark,
  output logic              out_bad_escape
);
  import esd_pkg::*;

  logic [1:0]      cnt_r;
  logic [2:0][7:0] b_r;
  logic            end_r;
  logic            bad_r;
  logic            pop;

  assign out_valid      = (cnt_r != 2'd0);
  assign pop            = out_valid && out_ready;
  assign out_byte_out   = b_r[0];
  assign out_end_mark   = end_r;
  assign out_bad_escape = bad_r;

  // The register can take a new group when empty or on its last transfer.
  assign free_o = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  // Byte count of the held group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load_i) begin
      cnt_r <= grp_i.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Group payload; each transfer shifts the next byte to the front.
  always_ff @(posedge clk) begin
    if (load_i) begin
      b_r   <= grp_i.b;
      end_r <= grp_i.end_mark;
      bad_r <= grp_i.bad;
    end else if (pop) begin
      b_r[0] <= b_r[1];
      b_r[1] <= b_r[2];
    end
  end

endmodule

// ===== rtl/core/escape_sequence_decoder.sv =====
// Top level of the string unescape decoder with UTF-8 output.
//
//   channel | direction | signals
//   in      | input     | in_valid, in_ready, in_char_in
//   out     | output    | out_valid, out_ready, out_byte_out, out_end_mark, out_bad_escape
//
// One input byte is taken per cycle while its results fit in the result register;
// it is decoded out of the input register in the next cycle, and its results leave
// the result register one per cycle while out_ready is high. A byte with several
// results holds back the next byte with results. Synchronous active-low reset
// returns the decoder to normal text mode. A stall on the output holds the result
// register and, once the input register holds a byte with results, lowers in_ready.
`timescale 1ns / 1ps

module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_out,
  output logic       out_end_mark,
  output logic       out_bad_escape
);
  import esd_pkg::*;

  logic       in_v_r;
  logic [7:0] in_char_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  dec_grp_t   grp;
  logic       grp_free;
  logic       adv;

  // A held byte moves on when its results fit in the result register.
  assign adv      = in_v_r && ((grp.cnt == 2'd0) || grp_free);
  assign in_ready = !in_v_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_in;
    end
  end

  // Decoder state advances with each byte that leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: MODE_TEXT, acc: 16'd0, skip: 1'b0};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  esd_decode u_decode (
    .char_i (in_char_r),
    .st_i   (st_r),
    .st_nxt (st_nxt),
    .grp_o  (grp)
  );

  esd_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (adv && (grp.cnt != 2'd0)),
    .grp_i          (grp),
    .free_o         (grp_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_out   (out_byte_out),
    .out_end_mark   (out_end_mark),
    .out_bad_escape (out_bad_escape)
  );

endmodule

// ===== rtl/core/esd_checker.sv =====
// Port-level checks for the escape sequence decoder, bound to the top level.
`timescale 1ns / 1ps

module esd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_out,
  input logic       out_end_mark,
  input logic       out_bad_escape
);

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_out) &&
      $stable(out_end_mark) && $stable(out_bad_escape))
    else $error("result changed while stalled");

  // An error flag only comes with an end marker.
  a_bad_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_escape |-> out_end_mark)
    else $error("bad_escape without end_mark");

  // End markers carry a zero data byte.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_mark |-> out_byte_out == 8'h00)
    else $error("end marker with nonzero byte");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte_out   (out_byte_out),
  .out_end_mark   (out_end_mark),
  .out_bad_escape (out_bad_escape)
);
